// File: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define EFJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define EFJ_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant check failed");

`endif

// File: rtl/efj_pkg.sv
`default_nettype none
package efj_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QW = 32;
  localparam int PW = 2 * QW;
  localparam int DENS_W = QW - 1;
  localparam int KAPPA_W = 18;
  localparam int QB = QW + 1;
  localparam int NW = QW + FRAC_BITS + 1;
  localparam int DIV_LAT = QB + 2;
  localparam int ARI_LAT = 7;
  localparam int LAT = DIV_LAT + ARI_LAT;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [PW-1:0] p_t;

  localparam q_t ONE_Q = q_t'(64'sd1 <<< FRAC_BITS);
  localparam q_t MAX_Q = {1'b0, {(QW-1){1'b1}}};
  localparam q_t MIN_Q = {1'b1, {(QW-1){1'b0}}};
  localparam p_t HALF_P = p_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic [KAPPA_W-1:0] KAPPA_RST = KAPPA_W'(91750);
  localparam logic [CFG_AW-3:0] REG_HEAT_RATIO = '0;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // {direction, row, column}
  localparam logic [4:0] SEL_X_R0C1 = 5'h01;
  localparam logic [4:0] SEL_X_R1C0 = 5'h04;
  localparam logic [4:0] SEL_X_R1C1 = 5'h05;
  localparam logic [4:0] SEL_X_R1C2 = 5'h06;
  localparam logic [4:0] SEL_X_R1C3 = 5'h07;
  localparam logic [4:0] SEL_X_R2C0 = 5'h08;
  localparam logic [4:0] SEL_X_R2C1 = 5'h09;
  localparam logic [4:0] SEL_X_R2C2 = 5'h0A;
  localparam logic [4:0] SEL_X_R3C0 = 5'h0C;
  localparam logic [4:0] SEL_X_R3C1 = 5'h0D;
  localparam logic [4:0] SEL_X_R3C2 = 5'h0E;
  localparam logic [4:0] SEL_X_R3C3 = 5'h0F;
  localparam logic [4:0] SEL_Y_R0C2 = 5'h12;
  localparam logic [4:0] SEL_Y_R1C0 = 5'h14;
  localparam logic [4:0] SEL_Y_R1C1 = 5'h15;
  localparam logic [4:0] SEL_Y_R1C2 = 5'h16;
  localparam logic [4:0] SEL_Y_R2C0 = 5'h18;
  localparam logic [4:0] SEL_Y_R2C1 = 5'h19;
  localparam logic [4:0] SEL_Y_R2C2 = 5'h1A;
  localparam logic [4:0] SEL_Y_R2C3 = 5'h1B;
  localparam logic [4:0] SEL_Y_R3C0 = 5'h1C;
  localparam logic [4:0] SEL_Y_R3C1 = 5'h1D;
  localparam logic [4:0] SEL_Y_R3C2 = 5'h1E;
  localparam logic [4:0] SEL_Y_R3C3 = 5'h1F;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    q_t                momentum_x;
    q_t                momentum_y;
    q_t                total_energy;
    logic              direction;
    logic [1:0]        row;
    logic [1:0]        column;
  } in_word_t;

  typedef struct packed {
    q_t         entry_value;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic       zero;
    logic [4:0] sel;
  } tag_t;

  typedef struct packed {
    logic sat;
    q_t   v;
  } qv_t;

  typedef struct packed {
    q_t g;
    q_t gm;
    q_t onem;
    q_t thm;
  } coef_t;

  localparam qv_t ZERO_QV = '{sat: 1'b0, v: '0};
  localparam qv_t ONE_QV = '{sat: 1'b0, v: ONE_Q};

  function automatic qv_t clip_wide(input p_t r);
    qv_t o;
    logic same;
    same = (&r[PW-1:QW-1]) | ~(|r[PW-1:QW-1]);
    o.sat = ~same;
    o.v = same ? r[QW-1:0] : (r[PW-1] ? MIN_Q : MAX_Q);
    return o;
  endfunction

  function automatic qv_t qmulr(input p_t p, input logic f);
    qv_t o;
    o = clip_wide((p + HALF_P) >>> FRAC_BITS);
    o.sat = o.sat | f;
    return o;
  endfunction

  function automatic qv_t qadd(input qv_t a, input qv_t b);
    qv_t o;
    o = clip_wide(p_t'(a.v) + p_t'(b.v));
    o.sat = o.sat | a.sat | b.sat;
    return o;
  endfunction

  function automatic qv_t qsub(input qv_t a, input qv_t b);
    qv_t o;
    o = clip_wide(p_t'(a.v) - p_t'(b.v));
    o.sat = o.sat | a.sat | b.sat;
    return o;
  endfunction

  // product with one half: floor((x + 1) / 2)
  function automatic qv_t qhalf(input qv_t a);
    qv_t o;
    p_t s;
    s = (p_t'(a.v) + p_t'(1)) >>> 1;
    o.v = s[QW-1:0];
    o.sat = a.sat;
    return o;
  endfunction

  function automatic coef_t coef_of(input logic [KAPPA_W-1:0] k);
    coef_t c;
    c.g = q_t'(k);
    c.gm = c.g - ONE_Q;
    c.onem = ONE_Q - c.g;
    c.thm = (ONE_Q <<< 1) + ONE_Q - c.g;
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/efj_cfg.sv
`default_nettype none
module efj_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efj_pkg::CFG_AW-1:0]  paddr,
  input  logic [efj_pkg::CFG_DW-1:0]  pwdata,
  output logic [efj_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output efj_pkg::coef_t              coef
);
  import efj_pkg::*;

  logic [KAPPA_W-1:0] heat_r;
  logic [KAPPA_W-1:0] heat_nxt;
  coef_t              coef_r;
  logic               hit;
  logic               wr;

  assign hit = (paddr[CFG_AW-1:2] == REG_HEAT_RATIO);
  assign wr = psel & penable & pwrite & hit;
  assign heat_nxt = wr ? pwdata[KAPPA_W-1:0] : heat_r;
  assign pready = 1'b1;
  assign prdata = hit ? {{(CFG_DW-KAPPA_W){1'b0}}, heat_r} : '0;
  assign coef = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r <= KAPPA_RST;
      coef_r <= coef_of(KAPPA_RST);
    end else begin
      heat_r <= heat_nxt;
      coef_r <= coef_of(heat_nxt);
    end
  end

endmodule
`default_nettype wire

// File: rtl/efj_div.sv
`default_nettype none
module efj_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  efj_pkg::tag_t               in_tag,
  input  logic [efj_pkg::DENS_W-1:0]  in_dens,
  input  efj_pkg::q_t [2:0]           in_num,
  output logic                        out_valid,
  output efj_pkg::tag_t               out_tag,
  output efj_pkg::qv_t [2:0]          out_q
);
  import efj_pkg::*;

  localparam logic [QB-1:0] QMAG_MIN = QB'(1) << (QW - 1);

  logic              vld_r [QB+1];
  tag_t              tag_r [QB+1];
  logic [DENS_W-1:0] den_r [QB];
  logic [NW-1:0]     rem_r [QB][3];
  logic [QB-1:0]     quo_r [QB+1][3];
  logic [2:0]        neg_r [QB+1];
  logic [2:0]        ovf_r [QB+1];

  logic [QW:0]       mag [3];
  logic [NW-1:0]     rem_nxt [3];
  logic [2:0]        ovf_nxt;
  qv_t [2:0]         res_nxt;
  logic              out_valid_r;
  tag_t              out_tag_r;
  qv_t [2:0]         out_q_r;

  // dividend = |num| << FRAC_BITS plus half the divisor, for round to nearest
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = in_num[l][QW-1] ? -{in_num[l][QW-1], in_num[l]} : {1'b0, in_num[l]};
      rem_nxt[l] = (NW'(mag[l]) << FRAC_BITS) + NW'(in_dens >> 1);
      ovf_nxt[l] = (rem_nxt[l] >> QB) >= NW'(in_dens);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    den_r[0] <= in_dens;
    neg_r[0] <= {in_num[2][QW-1], in_num[1][QW-1], in_num[0][QW-1]};
    ovf_r[0] <= ovf_nxt;
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] <= rem_nxt[l];
      quo_r[0][l] <= '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 1; k <= QB; k++) begin : g_bit
    localparam int B = QB - k;
    logic [2:0]    ge;
    logic [NW-1:0] sub [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        ge[l] = (rem_r[k-1][l] >> B) >= NW'(den_r[k-1]);
        sub[l] = ge[l] ? rem_r[k-1][l] - (NW'(den_r[k-1]) << B) : rem_r[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[k] <= tag_r[k-1];
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      for (int l = 0; l < 3; l++) begin
        quo_r[k][l] <= quo_r[k-1][l] | (QB'(ge[l]) << B);
      end
    end

    if (k < QB) begin : g_carry
      always_ff @(posedge clk) begin
        den_r[k] <= den_r[k-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l] <= sub[l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (neg_r[QB][l]) begin
        res_nxt[l].sat = ovf_r[QB][l] | (quo_r[QB][l] > QMAG_MIN);
        res_nxt[l].v = res_nxt[l].sat ? MIN_Q : -q_t'(quo_r[QB][l][QW-1:0]);
      end else begin
        res_nxt[l].sat = ovf_r[QB][l] | (quo_r[QB][l] >= QMAG_MIN);
        res_nxt[l].v = res_nxt[l].sat ? MAX_Q : q_t'(quo_r[QB][l][QW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r <= tag_r[QB];
    out_q_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tag = out_tag_r;
  assign out_q = out_q_r;

endmodule
`default_nettype wire

// File: rtl/efj_arith.sv
`default_nettype none
module efj_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  efj_pkg::tag_t      in_tag,
  input  efj_pkg::qv_t [2:0] in_q,
  input  efj_pkg::coef_t     coef,
  output logic               out_valid,
  output efj_pkg::out_word_t out_word
);
  import efj_pkg::*;

  // stage 1: first products
  logic v1_r;
  tag_t t1_r;
  qv_t  ux1_r, vy1_r;
  logic se1_r;
  p_t   p_uu1_r, p_vv1_r, p_uv1_r, p_ge1_r, p_thu1_r, p_thv1_r;
  p_t   p_omu1_r, p_omv1_r, p_gu1_r, p_gv1_r;

  // stage 2: rounded products, q2
  logic v2_r;
  tag_t t2_r;
  qv_t  ux2_r, vy2_r, uu2_r, vv2_r, uv2_r, ge2_r, thu2_r, thv2_r;
  qv_t  omu2_r, omv2_r, gu2_r, gv2_r, q2_2_r;
  qv_t  uu_c, vv_c;

  // stage 3: second products
  logic v3_r;
  tag_t t3_r;
  qv_t  ux3_r, vy3_r, uu3_r, vv3_r, uv3_r, ge3_r, thu3_r, thv3_r;
  qv_t  omu3_r, omv3_r, gu3_r, gv3_r;
  p_t   p_gq3_r, p_guu3_r, p_gvv3_r, p_ouv3_r;
  logic f_gq3_r, f_guu3_r, f_gvv3_r, f_ouv3_r;

  // stage 4
  logic v4_r;
  tag_t t4_r;
  qv_t  ux4_r, vy4_r, uu4_r, vv4_r, uv4_r, ge4_r, thu4_r, thv4_r;
  qv_t  omu4_r, omv4_r, gu4_r, gv4_r, gq4_r, guu4_r, gvv4_r, ouv4_r;

  // stage 5
  logic v5_r;
  tag_t t5_r;
  qv_t  ux5_r, vy5_r, uu5_r, vv5_r, thu5_r, thv5_r, omu5_r, omv5_r;
  qv_t  gu5_r, gv5_r, ouv5_r, hq5_r, tt5_r, da5_r, db5_r, nuv5_r;

  // stage 6
  logic v6_r;
  tag_t t6_r;
  qv_t  ux6_r, vy6_r, thu6_r, thv6_r, omu6_r, omv6_r, gu6_r, gv6_r;
  qv_t  ouv6_r, nuv6_r, e0d6_r, e1e6_r, e04_6_r, e18_6_r;
  p_t   p_ut6_r, p_vt6_r;
  logic f_ut6_r, f_vt6_r;

  qv_t       res;
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r <= in_tag;
    ux1_r <= in_q[0];
    vy1_r <= in_q[1];
    se1_r <= in_q[2].sat;
    p_uu1_r <= p_t'(in_q[0].v) * p_t'(in_q[0].v);
    p_vv1_r <= p_t'(in_q[1].v) * p_t'(in_q[1].v);
    p_uv1_r <= p_t'(in_q[0].v) * p_t'(in_q[1].v);
    p_ge1_r <= p_t'(coef.g) * p_t'(in_q[2].v);
    p_thu1_r <= p_t'(coef.thm) * p_t'(in_q[0].v);
    p_thv1_r <= p_t'(coef.thm) * p_t'(in_q[1].v);
    p_omu1_r <= p_t'(coef.onem) * p_t'(in_q[0].v);
    p_omv1_r <= p_t'(coef.onem) * p_t'(in_q[1].v);
    p_gu1_r <= p_t'(coef.g) * p_t'(in_q[0].v);
    p_gv1_r <= p_t'(coef.g) * p_t'(in_q[1].v);
  end

  always_comb begin
    uu_c = qmulr(p_uu1_r, ux1_r.sat);
    vv_c = qmulr(p_vv1_r, vy1_r.sat);
  end

  always_ff @(posedge clk) begin
    t2_r <= t1_r;
    ux2_r <= ux1_r;
    vy2_r <= vy1_r;
    uu2_r <= uu_c;
    vv2_r <= vv_c;
    q2_2_r <= qadd(uu_c, vv_c);
    uv2_r <= qmulr(p_uv1_r, ux1_r.sat | vy1_r.sat);
    ge2_r <= qmulr(p_ge1_r, se1_r);
    thu2_r <= qmulr(p_thu1_r, ux1_r.sat);
    thv2_r <= qmulr(p_thv1_r, vy1_r.sat);
    omu2_r <= qmulr(p_omu1_r, ux1_r.sat);
    omv2_r <= qmulr(p_omv1_r, vy1_r.sat);
    gu2_r <= qmulr(p_gu1_r, ux1_r.sat);
    gv2_r <= qmulr(p_gv1_r, vy1_r.sat);
  end

  always_ff @(posedge clk) begin
    t3_r <= t2_r;
    ux3_r <= ux2_r;
    vy3_r <= vy2_r;
    uu3_r <= uu2_r;
    vv3_r <= vv2_r;
    uv3_r <= uv2_r;
    ge3_r <= ge2_r;
    thu3_r <= thu2_r;
    thv3_r <= thv2_r;
    omu3_r <= omu2_r;
    omv3_r <= omv2_r;
    gu3_r <= gu2_r;
    gv3_r <= gv2_r;
    p_gq3_r <= p_t'(coef.gm) * p_t'(q2_2_r.v);
    p_guu3_r <= p_t'(coef.gm) * p_t'(uu2_r.v);
    p_gvv3_r <= p_t'(coef.gm) * p_t'(vv2_r.v);
    p_ouv3_r <= p_t'(coef.onem) * p_t'(uv2_r.v);
    f_gq3_r <= q2_2_r.sat;
    f_guu3_r <= uu2_r.sat;
    f_gvv3_r <= vv2_r.sat;
    f_ouv3_r <= uv2_r.sat;
  end

  always_ff @(posedge clk) begin
    t4_r <= t3_r;
    ux4_r <= ux3_r;
    vy4_r <= vy3_r;
    uu4_r <= uu3_r;
    vv4_r <= vv3_r;
    uv4_r <= uv3_r;
    ge4_r <= ge3_r;
    thu4_r <= thu3_r;
    thv4_r <= thv3_r;
    omu4_r <= omu3_r;
    omv4_r <= omv3_r;
    gu4_r <= gu3_r;
    gv4_r <= gv3_r;
    gq4_r <= qmulr(p_gq3_r, f_gq3_r);
    guu4_r <= qmulr(p_guu3_r, f_guu3_r);
    gvv4_r <= qmulr(p_gvv3_r, f_gvv3_r);
    ouv4_r <= qmulr(p_ouv3_r, f_ouv3_r);
  end

  always_ff @(posedge clk) begin
    t5_r <= t4_r;
    ux5_r <= ux4_r;
    vy5_r <= vy4_r;
    uu5_r <= uu4_r;
    vv5_r <= vv4_r;
    thu5_r <= thu4_r;
    thv5_r <= thv4_r;
    omu5_r <= omu4_r;
    omv5_r <= omv4_r;
    gu5_r <= gu4_r;
    gv5_r <= gv4_r;
    ouv5_r <= ouv4_r;
    hq5_r <= qhalf(gq4_r);
    tt5_r <= qsub(gq4_r, ge4_r);
    da5_r <= qsub(ge4_r, guu4_r);
    db5_r <= qsub(ge4_r, gvv4_r);
    nuv5_r <= qsub(ZERO_QV, uv4_r);
  end

  always_ff @(posedge clk) begin
    t6_r <= t5_r;
    ux6_r <= ux5_r;
    vy6_r <= vy5_r;
    thu6_r <= thu5_r;
    thv6_r <= thv5_r;
    omu6_r <= omu5_r;
    omv6_r <= omv5_r;
    gu6_r <= gu5_r;
    gv6_r <= gv5_r;
    ouv6_r <= ouv5_r;
    nuv6_r <= nuv5_r;
    e0d6_r <= qsub(da5_r, hq5_r);
    e1e6_r <= qsub(db5_r, hq5_r);
    e04_6_r <= qsub(hq5_r, uu5_r);
    e18_6_r <= qsub(hq5_r, vv5_r);
    p_ut6_r <= p_t'(ux5_r.v) * p_t'(tt5_r.v);
    p_vt6_r <= p_t'(vy5_r.v) * p_t'(tt5_r.v);
    f_ut6_r <= ux5_r.sat | tt5_r.sat;
    f_vt6_r <= vy5_r.sat | tt5_r.sat;
  end

  always_comb begin
    case (t6_r.sel)
      SEL_X_R0C1, SEL_Y_R0C2: res = ONE_QV;
      SEL_X_R1C0: res = e04_6_r;
      SEL_X_R1C1: res = thu6_r;
      SEL_X_R1C2: res = omv6_r;
      SEL_X_R1C3, SEL_Y_R2C3: res = '{sat: 1'b0, v: coef.gm};
      SEL_X_R2C0, SEL_Y_R1C0: res = nuv6_r;
      SEL_X_R2C1, SEL_Y_R1C1: res = vy6_r;
      SEL_X_R2C2, SEL_Y_R1C2: res = ux6_r;
      SEL_X_R3C0: res = qmulr(p_ut6_r, f_ut6_r);
      SEL_X_R3C1: res = e0d6_r;
      SEL_X_R3C2, SEL_Y_R3C1: res = ouv6_r;
      SEL_X_R3C3: res = gu6_r;
      SEL_Y_R2C0: res = e18_6_r;
      SEL_Y_R2C1: res = omu6_r;
      SEL_Y_R2C2: res = thv6_r;
      SEL_Y_R3C0: res = qmulr(p_vt6_r, f_vt6_r);
      SEL_Y_R3C2: res = e1e6_r;
      SEL_Y_R3C3: res = gv6_r;
      default: res = ZERO_QV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t6_r.zero) begin
      out_word_r.entry_value <= '0;
      out_word_r.status <= ST_ZERO;
    end else begin
      out_word_r.entry_value <= res.v;
      out_word_r.status <= res.sat ? ST_SAT : ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule
`default_nettype wire

// File: rtl/euler_flux_jacobian_entry.sv
`default_nettype none
// One entry of the 2D Euler flux Jacobian per word, Q16.16. A word is taken
// on any cycle start is high (busy stays low), so a new word may enter every
// cycle. Its result shows on out_word for one cycle with out_strobe, after
// passing, in order, the bit-per-stage divider that forms u, v and E and
// then the multiply/round/add pipeline. The receiver cannot stall the
// result. heat_ratio sits at APB address 0; change it only while no word is
// in flight.
module euler_flux_jacobian_entry (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  efj_pkg::in_word_t           in_word,
  output logic                        out_strobe,
  output efj_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [efj_pkg::CFG_AW-1:0]  paddr,
  input  logic [efj_pkg::CFG_DW-1:0]  pwdata,
  output logic [efj_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import efj_pkg::*;

  coef_t     coef;
  tag_t      in_tag;
  q_t [2:0]  num;
  logic      div_valid;
  tag_t      div_tag;
  qv_t [2:0] div_q;

  assign busy = 1'b0;
  assign in_tag.zero = (in_word.density == '0);
  assign in_tag.sel = {in_word.direction, in_word.row, in_word.column};
  assign num = {in_word.total_energy, in_word.momentum_y, in_word.momentum_x};

  efj_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  efj_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_tag    (in_tag),
    .in_dens   (in_word.density),
    .in_num    (num),
    .out_valid (div_valid),
    .out_tag   (div_tag),
    .out_q     (div_q)
  );

  efj_arith u_arith (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_valid),
    .in_tag    (div_tag),
    .in_q      (div_q),
    .coef      (coef),
    .out_valid (out_strobe),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

// File: rtl/efj_checker.sv
`default_nettype none
`include "assert_macros.svh"
module efj_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input efj_pkg::in_word_t           in_word,
  input logic                        out_strobe,
  input efj_pkg::out_word_t          out_word,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [efj_pkg::CFG_AW-1:0]  paddr,
  input logic [efj_pkg::CFG_DW-1:0]  pwdata,
  input logic [efj_pkg::CFG_DW-1:0]  prdata,
  input logic                        pready
);
  import efj_pkg::*;

  `EFJ_ASSERT_IMP(a_word_out, start && !busy, ##LAT out_strobe)
  `EFJ_ASSERT_IMP(a_no_spurious, out_strobe, $past(start && !busy, LAT))
  `EFJ_ASSERT_IMP(a_zero_dens, out_strobe && ($past(in_word.density, LAT) == '0), (out_word.status == ST_ZERO) && (out_word.entry_value == '0))
  `EFJ_ASSERT_ALWAYS(a_status_code, !out_strobe || (out_word.status == ST_OK) || (out_word.status == ST_ZERO) || (out_word.status == ST_SAT))

endmodule

bind euler_flux_jacobian_entry efj_checker u_efj_checker (.*);
`default_nettype wire
